// ----- src/tpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Timer/PWM/capture package
// Shared types, register indexes and defaults for the timer unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tpc_pkg;

   localparam int COUNTER_BITS_DEFAULT  = 16;
   localparam int CHANNEL_COUNT_DEFAULT = 4;
   localparam int MAX_CHANNELS          = 4;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam logic [3:0] REG_CONTROL   = 4'd0;
   localparam logic [3:0] REG_IRQ_EN    = 4'd1;
   localparam logic [3:0] REG_STATUS    = 4'd2;
   localparam logic [3:0] REG_EVENT     = 4'd3;
   localparam logic [3:0] REG_MODE_LO   = 4'd4;
   localparam logic [3:0] REG_MODE_HI   = 4'd5;
   localparam logic [3:0] REG_ENABLE    = 4'd6;
   localparam logic [3:0] REG_COUNTER   = 4'd7;
   localparam logic [3:0] REG_PRESCALER = 4'd8;
   localparam logic [3:0] REG_RELOAD    = 4'd9;
   localparam logic [3:0] REG_COMPARE1  = 4'd10;
   localparam logic [3:0] REG_COMPARE2  = 4'd11;
   localparam logic [3:0] REG_COMPARE3  = 4'd12;
   localparam logic [3:0] REG_COMPARE4  = 4'd13;

   localparam logic [1:0] DIR_OUTPUT   = 2'd0;
   localparam logic [1:0] DIR_OWN_PIN  = 2'd1;
   localparam logic [1:0] DIR_NEIGHBOR = 2'd2;
   localparam logic [2:0] OC_PWM1      = 3'd6;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  reg_index;
      logic [15:0] write_data;
      logic [3:0]  capture_pins;
   } req_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic [3:0]  pwm_out;
      logic        interrupt_request;
      logic        update_event;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/timer_pwm_capture_unit.sv -----
// ----------------------------------------------------------------------------
// Timer/PWM/capture unit
// General purpose timer with PWM outputs and input capture behind registers.
// ----------------------------------------------------------------------------
// One item per clock while the output can drain: each accepted tick, write or read
// updates the timer state in the same cycle and its result lands in a single output
// register, so a result is presented in the cycle after acceptance. The request side stays
// ready while the result register is empty or being drained this cycle.
`default_nettype none

module timer_pwm_capture_unit #(
   parameter int COUNTER_BITS  = tpc_pkg::COUNTER_BITS_DEFAULT,
   parameter int CHANNEL_COUNT = tpc_pkg::CHANNEL_COUNT_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire tpc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output tpc_pkg::rsp_type      rsp_data
);

   logic             take;
   logic             rsp_valid_ff;
   tpc_pkg::rsp_type rsp_data_ff, core_rsp;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   tpc_core #(
      .COUNTER_BITS  (COUNTER_BITS),
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (take),
      .item       (req_data),
      .result     (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= take;
      end
      if (take) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- src/tpc_core.sv -----
// ----------------------------------------------------------------------------
// Timer core
// Register file, prescaler, counter, compare and capture; one item per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tpc_core #(
   parameter int COUNTER_BITS  = tpc_pkg::COUNTER_BITS_DEFAULT,
   parameter int CHANNEL_COUNT = tpc_pkg::CHANNEL_COUNT_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             item_valid,
   input  wire tpc_pkg::req_type item,
   output tpc_pkg::rsp_type      result
);

   localparam int CB = COUNTER_BITS;
   localparam int NC = tpc_pkg::MAX_CHANNELS;

   logic [CB-1:0] count_ff, count_in;
   logic [15:0]   psc_cnt_ff, psc_cnt_in, psc_act_ff, psc_act_in, psc_pend_ff, psc_pend_in;
   logic [CB-1:0] arr_act_ff, arr_act_in, arr_pend_ff, arr_pend_in;
   logic [CB-1:0] cmp_act_ff [NC];
   logic [CB-1:0] cmp_act_in [NC];
   logic [CB-1:0] cmp_pend_ff [NC];
   logic [CB-1:0] cmp_pend_in [NC];
   logic [7:0]    ctrl_ff, ctrl_in;
   logic [4:0]    ier_ff, ier_in, sr_ff, sr_in;
   logic [15:0]   mode_ff [2];
   logic [15:0]   mode_in [2];
   logic [15:0]   ccer_ff, ccer_in;
   logic [3:0]    prev_ff, prev_in;

   logic [7:0]    cmode   [NC];
   logic [NC-1:0] is_out, ch_en, ch_pol, ch_live;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         cmode[c]   = mode_ff[c/2][8*(c%2) +: 8];
         is_out[c]  = (cmode[c][1:0] == tpc_pkg::DIR_OUTPUT);
         ch_en[c]   = ccer_ff[4*c];
         ch_pol[c]  = ccer_ff[4*c+1];
         ch_live[c] = (c < CHANNEL_COUNT);
      end
   end

   logic          wrapped, psc_fire;
   logic [15:0]   rd;
   logic [CB-1:0] step_val;
   logic [15:0]   wd;
   logic [CB-1:0] wd_cnt;
   logic [NC-1:0] pin_now, pin_was, edge_hit;
   logic [3:0]    pwm;
   logic          down_in;
   logic [1:0]    sel;
   logic [1:0]    cmp_sel;

   always_comb begin
      count_in    = count_ff;
      psc_cnt_in  = psc_cnt_ff;
      psc_act_in  = psc_act_ff;
      psc_pend_in = psc_pend_ff;
      arr_act_in  = arr_act_ff;
      arr_pend_in = arr_pend_ff;
      ctrl_in     = ctrl_ff;
      ier_in      = ier_ff;
      sr_in       = sr_ff;
      mode_in     = mode_ff;
      ccer_in     = ccer_ff;
      prev_in     = prev_ff;
      cmp_act_in  = cmp_act_ff;
      cmp_pend_in = cmp_pend_ff;
      wrapped     = 1'b0;
      psc_fire    = 1'b0;
      rd          = '0;
      step_val    = count_ff;
      wd          = item.write_data;
      wd_cnt      = CB'(wd);
      pin_now     = '0;
      pin_was     = '0;
      edge_hit    = '0;
      sel         = '0;
      cmp_sel     = 2'(item.reg_index - tpc_pkg::REG_COMPARE1);

      if (item_valid) begin
         case (item.command)
            tpc_pkg::CMD_TICK: begin
               if (ctrl_ff[0]) begin
                  if (psc_cnt_ff >= psc_act_ff) begin
                     psc_cnt_in = '0;
                     psc_fire   = 1'b1;
                  end else begin
                     psc_cnt_in = psc_cnt_ff + 16'd1;
                  end
               end
               if (psc_fire) begin
                  if (!ctrl_ff[4]) begin
                     if (count_ff >= arr_act_ff) begin
                        step_val = '0;
                        wrapped  = 1'b1;
                     end else begin
                        step_val = count_ff + CB'(1);
                     end
                  end else begin
                     if (count_ff == '0) begin
                        step_val = arr_act_ff;
                        wrapped  = 1'b1;
                     end else begin
                        step_val = count_ff - CB'(1);
                     end
                  end
                  count_in = step_val;
                  if (wrapped) begin
                     sr_in[0]   = 1'b1;
                     psc_act_in = psc_pend_ff;
                     arr_act_in = arr_pend_ff;
                     for (int c = 0; c < NC; c++)
                        if (ch_live[c] && is_out[c]) cmp_act_in[c] = cmp_pend_ff[c];
                  end
                  for (int c = 0; c < NC; c++)
                     if (ch_live[c] && is_out[c] && step_val == cmp_act_in[c])
                        sr_in[c+1] = 1'b1;
               end
               for (int c = 0; c < NC; c++) begin
                  sel = cmode[c][1:0];
                  pin_now[c] = (sel == tpc_pkg::DIR_OWN_PIN) ? item.capture_pins[c]
                                                             : item.capture_pins[c^1];
                  pin_was[c] = (sel == tpc_pkg::DIR_OWN_PIN) ? prev_ff[c] : prev_ff[c^1];
                  edge_hit[c] = ch_live[c] && ch_en[c] &&
                                (sel == tpc_pkg::DIR_OWN_PIN || sel == tpc_pkg::DIR_NEIGHBOR) &&
                                (ch_pol[c] ? (pin_was[c] && !pin_now[c])
                                           : (!pin_was[c] && pin_now[c]));
                  if (edge_hit[c]) begin
                     cmp_act_in[c]  = step_val;
                     cmp_pend_in[c] = step_val;
                     sr_in[c+1]     = 1'b1;
                  end
               end
               prev_in = item.capture_pins;
            end
            tpc_pkg::CMD_WRITE: begin
               case (item.reg_index)
                  tpc_pkg::REG_CONTROL: ctrl_in = wd[7:0];
                  tpc_pkg::REG_IRQ_EN:  ier_in  = wd[4:0];
                  tpc_pkg::REG_STATUS:  sr_in   = sr_ff & wd[4:0];
                  tpc_pkg::REG_EVENT: begin
                     if (wd[0]) begin
                        psc_act_in = psc_pend_ff;
                        arr_act_in = arr_pend_ff;
                        for (int c = 0; c < NC; c++)
                           if (ch_live[c] && is_out[c]) cmp_act_in[c] = cmp_pend_ff[c];
                        psc_cnt_in = '0;
                        count_in   = ctrl_ff[4] ? arr_pend_ff : '0;
                        sr_in[0]   = 1'b1;
                     end
                     for (int c = 0; c < NC; c++) begin
                        if (ch_live[c] && wd[c+1]) begin
                           sr_in[c+1] = 1'b1;
                           if (!is_out[c]) begin
                              cmp_act_in[c]  = count_in;
                              cmp_pend_in[c] = count_in;
                           end
                        end
                     end
                  end
                  tpc_pkg::REG_MODE_LO:   mode_in[0]  = wd;
                  tpc_pkg::REG_MODE_HI:   mode_in[1]  = wd;
                  tpc_pkg::REG_ENABLE:    ccer_in     = wd;
                  tpc_pkg::REG_COUNTER:   count_in    = wd_cnt;
                  tpc_pkg::REG_PRESCALER: psc_pend_in = wd;
                  tpc_pkg::REG_RELOAD: begin
                     arr_pend_in = wd_cnt;
                     if (!ctrl_ff[7]) arr_act_in = wd_cnt;
                  end
                  tpc_pkg::REG_COMPARE1, tpc_pkg::REG_COMPARE2,
                  tpc_pkg::REG_COMPARE3, tpc_pkg::REG_COMPARE4: begin
                     for (int c = 0; c < NC; c++) begin
                        if (cmp_sel == 2'(c) && ch_live[c] && is_out[c]) begin
                           cmp_pend_in[c] = wd_cnt;
                           if (!cmode[c][3]) cmp_act_in[c] = wd_cnt;
                        end
                     end
                  end
                  default: ;
               endcase
            end
            tpc_pkg::CMD_READ: begin
               case (item.reg_index)
                  tpc_pkg::REG_CONTROL:   rd = {8'd0, ctrl_ff};
                  tpc_pkg::REG_IRQ_EN:    rd = {11'd0, ier_ff};
                  tpc_pkg::REG_STATUS:    rd = {11'd0, sr_ff};
                  tpc_pkg::REG_MODE_LO:   rd = mode_ff[0];
                  tpc_pkg::REG_MODE_HI:   rd = mode_ff[1];
                  tpc_pkg::REG_ENABLE:    rd = ccer_ff;
                  tpc_pkg::REG_COUNTER:   rd = 16'(count_ff);
                  tpc_pkg::REG_PRESCALER: rd = psc_pend_ff;
                  tpc_pkg::REG_RELOAD:    rd = 16'(arr_pend_ff);
                  tpc_pkg::REG_COMPARE1, tpc_pkg::REG_COMPARE2,
                  tpc_pkg::REG_COMPARE3, tpc_pkg::REG_COMPARE4: begin
                     for (int c = 0; c < NC; c++) begin
                        if (cmp_sel == 2'(c) && ch_live[c]) begin
                           rd = 16'(cmp_pend_ff[c]);
                           if (!is_out[c]) sr_in[c+1] = 1'b0;
                        end
                     end
                  end
                  default: rd = '0;
               endcase
            end
            default: ;
         endcase
      end

      // outputs from next state
      down_in = ctrl_in[4];
      pwm = '0;
      for (int c = 0; c < NC; c++) begin
         if (ch_live[c] && mode_in[c/2][8*(c%2) +: 2] == tpc_pkg::DIR_OUTPUT &&
             ccer_in[4*c]) begin
            pwm[c] = (mode_in[c/2][8*(c%2)+4 +: 3] == tpc_pkg::OC_PWM1) &&
                     (down_in ? (count_in <= cmp_act_in[c]) : (count_in < cmp_act_in[c]));
            pwm[c] = pwm[c] ^ ccer_in[4*c+1];
         end
      end
      result.read_data         = rd;
      result.pwm_out           = pwm;
      result.interrupt_request = |(sr_in & ier_in);
      result.update_event      = wrapped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         psc_cnt_ff  <= '0;
         psc_act_ff  <= '0;
         psc_pend_ff <= '0;
         arr_act_ff  <= '1;
         arr_pend_ff <= '1;
         ctrl_ff     <= '0;
         ier_ff      <= '0;
         sr_ff       <= '0;
         mode_ff     <= '{default: '0};
         ccer_ff     <= '0;
         prev_ff     <= '0;
         cmp_act_ff  <= '{default: '0};
         cmp_pend_ff <= '{default: '0};
      end else begin
         count_ff    <= count_in;
         psc_cnt_ff  <= psc_cnt_in;
         psc_act_ff  <= psc_act_in;
         psc_pend_ff <= psc_pend_in;
         arr_act_ff  <= arr_act_in;
         arr_pend_ff <= arr_pend_in;
         ctrl_ff     <= ctrl_in;
         ier_ff      <= ier_in;
         sr_ff       <= sr_in;
         mode_ff     <= mode_in;
         ccer_ff     <= ccer_in;
         prev_ff     <= prev_in;
         cmp_act_ff  <= cmp_act_in;
         cmp_pend_ff <= cmp_pend_in;
      end
   end

endmodule

`default_nettype wire
